// ===== rtl/prm_pkg.sv =====
package prm_pkg;

  localparam int TICKS_PER_SECOND = 100;
  localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1);
  localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_SECOND - 1);

  localparam int BPM_W = 10;
  localparam int SUM_W = 12;
  localparam int RECIP_W = 17;
  // floor(x / 3) == (x * 43691) >> 17 for every x below 2**16
  localparam logic [RECIP_W-1:0] RECIP_THIRD = 17'd43691;

  localparam logic [5:0] BEAT_SAT = 6'd63;
  localparam logic [5:0] DROP_ABOVE = 6'd8;
  localparam logic [15:0] EVENT_SAT = 16'hFFFF;
  localparam logic [5:0] SECONDS_LAST = 6'd59;
  localparam logic [5:0] MINUTES_LAST = 6'd59;
  localparam logic [4:0] HOURS_LAST = 5'd23;
  localparam int RING_DEPTH = 3;
  localparam logic [1:0] RING_LAST = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  localparam logic REG_LOW_BOUND = 1'b0;
  localparam logic REG_HIGH_BOUND = 1'b1;
  localparam logic [6:0] LOW_BOUND_RESET = 7'd30;
  localparam logic [7:0] HIGH_BOUND_RESET = 8'd120;

  // one classified tick, handed from the front to the back
  typedef struct packed {
    logic             level;
    logic             restart;
    logic             done;
    logic [BPM_W-1:0] bpm;
    logic [4:0]       hours;
    logic [5:0]       minutes;
    logic [5:0]       seconds;
  } work_item_t;

  typedef struct packed {
    logic             pulse_led;
    logic             low_alarm;
    logic             high_alarm;
    logic             window_done;
    logic [BPM_W-1:0] average_bpm;
    logic [4:0]       clock_hours;
    logic [5:0]       clock_minutes;
    logic [5:0]       clock_seconds;
    logic [BPM_W-1:0] lowest_bpm;
    logic [BPM_W-1:0] highest_bpm;
    logic [15:0]      low_alarm_count;
    logic [15:0]      high_alarm_count;
  } out_item_t;

  typedef struct packed {
    logic [6:0] low_bound;
    logic [7:0] high_bound;
  } bounds_t;

endpackage

// ===== rtl/pulse_rate_monitor_with_alarms_core.sv =====
// Pulse rate monitor: each input transfer is one sensor tick (10 ms at 100 ticks per
// second) and yields exactly one output transfer carrying the pulse LED, alarm flags,
// window flag, three-window average bpm, session clock, lowest/highest bpm and the
// saturating alarm counts. One tick is taken every cycle while the queue has room;
// the tick is written into the two-entry queue between the clock/beat front end and
// the window back end, and the back end loads the output register when it pops the
// entry. Input is held off only when the queue is full because the output side
// stalls. Bounds are written over APB at byte 0 (low, 7 bits) and byte 4 (high, 8
// bits); the user must write them only while idle, which the block does not enforce.
module pulse_rate_monitor_with_alarms_core
  import prm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] pulse_level, [1] restart, [7:2] zero
  input  logic [7:0]  s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] pulse_led, [1] low_alarm, [2] high_alarm, [3] window_done, [13:4] average_bpm,
  // [18:14] clock_hours, [24:19] clock_minutes, [30:25] clock_seconds,
  // [40:31] lowest_bpm, [50:41] highest_bpm, [66:51] low_alarm_count,
  // [82:67] high_alarm_count, [87:83] zero
  output logic [87:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bounds_t    bounds;
  work_item_t front_item;
  work_item_t queue_item;
  out_item_t  out_data;
  logic       queue_full;
  logic       queue_valid;
  logic       pop;
  logic       accept;

  assign pready   = 1'b1;
  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds.low_bound  <= LOW_BOUND_RESET;
      bounds.high_bound <= HIGH_BOUND_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_LOW_BOUND:  bounds.low_bound  <= pwdata[6:0];
        REG_HIGH_BOUND: bounds.high_bound <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LOW_BOUND:  prdata = {25'd0, bounds.low_bound};
      REG_HIGH_BOUND: prdata = {24'd0, bounds.high_bound};
      default:        prdata = '0;
    endcase
  end

  prm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pulse_level (s_tdata[0]),
    .restart     (s_tdata[1]),
    .item        (front_item)
  );

  prm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_valid),
    .pop_data  (queue_item)
  );

  prm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .bounds     (bounds),
    .item_valid (queue_valid),
    .item       (queue_item),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_data)
  );

  assign m_tdata = {5'd0,
                    out_data.high_alarm_count,
                    out_data.low_alarm_count,
                    out_data.highest_bpm,
                    out_data.lowest_bpm,
                    out_data.clock_seconds,
                    out_data.clock_minutes,
                    out_data.clock_hours,
                    out_data.average_bpm,
                    out_data.window_done,
                    out_data.high_alarm,
                    out_data.low_alarm,
                    out_data.pulse_led};

endmodule

// ===== rtl/prm_front.sv =====
module prm_front
  import prm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       pulse_level,
  input  logic       restart,
  output work_item_t item
);

  logic [TICK_W-1:0] tick_counter, tick_counter_next;
  logic [5:0]        seconds_count, seconds_count_next;
  logic [5:0]        minutes_count, minutes_count_next;
  logic [4:0]        hours_count, hours_count_next;
  logic              previous_level, previous_level_next;
  logic [5:0]        beats, beats_next;
  logic [5:0]        beats_cnt;
  logic [5:0]        adj;
  logic [BPM_W-1:0]  adj_ext;
  logic              close;

  always_comb begin
    tick_counter_next   = tick_counter;
    seconds_count_next  = seconds_count;
    minutes_count_next  = minutes_count;
    hours_count_next    = hours_count;
    previous_level_next = pulse_level;
    beats_next          = beats;
    beats_cnt           = beats;
    close               = 1'b0;
    adj                 = '0;
    adj_ext             = '0;
    item.bpm            = '0;
    if (restart) begin
      tick_counter_next  = '0;
      seconds_count_next = '0;
      minutes_count_next = '0;
      hours_count_next   = '0;
      beats_next         = '0;
    end else begin
      if (previous_level && !pulse_level && beats != BEAT_SAT) begin
        beats_cnt = beats + 6'd1;
      end
      beats_next = beats_cnt;
      if (tick_counter >= TICK_LAST) begin
        tick_counter_next = '0;
        if (seconds_count >= SECONDS_LAST) begin
          seconds_count_next = '0;
          if (minutes_count >= MINUTES_LAST) begin
            minutes_count_next = '0;
            hours_count_next = (hours_count >= HOURS_LAST) ? 5'd0 : hours_count + 5'd1;
          end else begin
            minutes_count_next = minutes_count + 6'd1;
          end
        end else begin
          seconds_count_next = seconds_count + 6'd1;
        end
        close = seconds_count_next inside {6'd0, 6'd5, 6'd10, 6'd15, 6'd20, 6'd25,
                                           6'd30, 6'd35, 6'd40, 6'd45, 6'd50, 6'd55};
      end else begin
        tick_counter_next = tick_counter + TICK_W'(1);
      end
      if (close) begin
        // drop one beat above eight, then one more for the beat that opened the window
        adj = (beats_cnt > DROP_ABOVE) ? beats_cnt - 6'd1 : beats_cnt;
        if (adj != 6'd0) begin
          adj_ext = BPM_W'(adj - 6'd1);
          item.bpm = (adj_ext << 3) + (adj_ext << 2);
        end
        beats_next = '0;
      end
    end
    item.level   = pulse_level;
    item.restart = restart;
    item.done    = close;
    item.hours   = hours_count_next;
    item.minutes = minutes_count_next;
    item.seconds = seconds_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter   <= '0;
      seconds_count  <= '0;
      minutes_count  <= '0;
      hours_count    <= '0;
      previous_level <= 1'b0;
      beats          <= '0;
    end else if (accept) begin
      tick_counter   <= tick_counter_next;
      seconds_count  <= seconds_count_next;
      minutes_count  <= minutes_count_next;
      hours_count    <= hours_count_next;
      previous_level <= previous_level_next;
      beats          <= beats_next;
    end
  end

endmodule

// ===== rtl/prm_fifo.sv =====
module prm_fifo
  import prm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  work_item_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output work_item_t pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_item_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> count == CNT_W'(QUEUE_DEPTH))
    else $error("queue lost an entry while full");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not drain the queue");
`endif

endmodule

// ===== rtl/prm_back.sv =====
module prm_back
  import prm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bounds_t    bounds,
  input  logic       item_valid,
  input  work_item_t item,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  logic [BPM_W-1:0] ring [RING_DEPTH];
  logic [BPM_W-1:0] ring_next [RING_DEPTH];
  logic [1:0]       ring_slot, ring_slot_next;
  logic [1:0]       windows_filled, windows_filled_next;
  logic [BPM_W-1:0] min_seen, min_seen_next;
  logic [BPM_W-1:0] max_seen, max_seen_next;
  logic             have_min, have_min_next;
  logic             low_flag, low_flag_next;
  logic             high_flag, high_flag_next;
  logic [15:0]      low_events, low_events_next;
  logic [15:0]      high_events, high_events_next;
  logic [SUM_W-1:0] ring_sum;
  logic [SUM_W+RECIP_W-1:0] avg_prod;
  out_item_t        result;

  assign pop = item_valid && (!out_valid || out_ready);

  always_comb begin
    for (int k = 0; k < RING_DEPTH; k++) begin
      ring_next[k] = ring[k];
    end
    ring_slot_next      = ring_slot;
    windows_filled_next = windows_filled;
    min_seen_next       = min_seen;
    max_seen_next       = max_seen;
    have_min_next       = have_min;
    low_flag_next       = low_flag;
    high_flag_next      = high_flag;
    low_events_next     = low_events;
    high_events_next    = high_events;
    if (item.restart) begin
      for (int k = 0; k < RING_DEPTH; k++) begin
        ring_next[k] = '0;
      end
      ring_slot_next      = '0;
      windows_filled_next = '0;
      min_seen_next       = '0;
      max_seen_next       = '0;
      have_min_next       = 1'b0;
      low_flag_next       = 1'b0;
      high_flag_next      = 1'b0;
      low_events_next     = '0;
      high_events_next    = '0;
    end else if (item.done) begin
      if (!have_min || item.bpm < min_seen) begin
        min_seen_next = item.bpm;
      end
      have_min_next = 1'b1;
      if (item.bpm > max_seen) begin
        max_seen_next = item.bpm;
      end
      if (item.bpm < BPM_W'(bounds.low_bound)) begin
        low_flag_next = 1'b1;
        if (low_events != EVENT_SAT) begin
          low_events_next = low_events + 16'd1;
        end
      end else if (item.bpm > BPM_W'(bounds.high_bound)) begin
        high_flag_next = 1'b1;
        if (high_events != EVENT_SAT) begin
          high_events_next = high_events + 16'd1;
        end
      end else begin
        low_flag_next  = 1'b0;
        high_flag_next = 1'b0;
      end
      // seed the slots above the current one until the ring has seen three windows
      for (int k = 0; k < RING_DEPTH; k++) begin
        if (2'(k) == ring_slot || (windows_filled != 2'd3 && 2'(k) > ring_slot)) begin
          ring_next[k] = item.bpm;
        end
      end
      if (windows_filled != 2'd3) begin
        windows_filled_next = windows_filled + 2'd1;
      end
      ring_slot_next = (ring_slot >= RING_LAST) ? 2'd0 : ring_slot + 2'd1;
    end
    ring_sum = SUM_W'(ring_next[0]) + SUM_W'(ring_next[1]) + SUM_W'(ring_next[2]);
    avg_prod = ring_sum * RECIP_THIRD;

    result.pulse_led        = item.level;
    result.low_alarm        = low_flag_next;
    result.high_alarm       = high_flag_next;
    result.window_done      = item.done;
    result.average_bpm      = avg_prod[RECIP_W +: BPM_W];
    result.clock_hours      = item.hours;
    result.clock_minutes    = item.minutes;
    result.clock_seconds    = item.seconds;
    result.lowest_bpm       = min_seen_next;
    result.highest_bpm      = max_seen_next;
    result.low_alarm_count  = low_events_next;
    result.high_alarm_count = high_events_next;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RING_DEPTH; k++) begin
        ring[k] <= '0;
      end
      ring_slot      <= '0;
      windows_filled <= '0;
      min_seen       <= '0;
      max_seen       <= '0;
      have_min       <= 1'b0;
      low_flag       <= 1'b0;
      high_flag      <= 1'b0;
      low_events     <= '0;
      high_events    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        for (int k = 0; k < RING_DEPTH; k++) begin
          ring[k] <= ring_next[k];
        end
        ring_slot      <= ring_slot_next;
        windows_filled <= windows_filled_next;
        min_seen       <= min_seen_next;
        max_seen       <= max_seen_next;
        have_min       <= have_min_next;
        low_flag       <= low_flag_next;
        high_flag      <= high_flag_next;
        low_events     <= low_events_next;
        high_events    <= high_events_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    pop && item.restart |=> low_events == '0 && high_events == '0 && !have_min)
    else $error("restart left session counts behind");
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    ring_slot <= RING_LAST)
    else $error("ring slot out of range");
  a_min_holds: assert property (@(posedge clk) disable iff (rst)
    pop && !item.restart && !item.done |=> $stable(min_seen) && $stable(low_events))
    else $error("window state moved on a tick that closed no window");
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    have_min |-> min_seen <= max_seen)
    else $error("lowest bpm above highest bpm");
`endif

endmodule
